// ===== design/vpa_pkg.sv =====
// Shared types and constants for the variable partition allocator.
// No dependencies; every other design file imports this package.
package vpa_pkg;

	localparam int MEM_UNITS = 1024;
	localparam int MAX_SEGS  = 1024;
	localparam int AW        = $clog2(MAX_SEGS);      // table index width
	localparam int SW        = $clog2(MEM_UNITS) + 1; // segment size width
	localparam int CW        = $clog2(MAX_SEGS) + 1;  // segment count width
	localparam int LW        = 16;                    // eviction LFSR width
	localparam int RW        = 11;                    // request_size width
	localparam int EW        = 10;                    // eviction_count width
	localparam int HW        = 11;                    // holes_examined width
	localparam int IW        = 2;                     // config index width

	localparam logic [IW-1:0] REG_FIT_POLICY  = 2'd0;
	localparam logic [IW-1:0] REG_VICTIM_SEED = 2'd1;

	localparam logic [1:0] POL_BEST  = 2'd0;
	localparam logic [1:0] POL_WORST = 2'd1;

	typedef struct packed {
		logic [SW-1:0] size;
		logic          hole;
	} ent_t;

	typedef enum logic [4:0] {
		S_IDLE, S_SCAN_RD, S_SCAN_EV, S_DECIDE, S_EVST, S_DIV, S_VF_RD, S_VF_EV,
		S_RN_RD, S_MERGE, S_MLOOP, S_MSH_RD, S_MSH_WR, S_MEND, S_PLACE, S_PLOOP,
		S_PSH_RD, S_PSH_WR, S_PFIX_R, S_PFIX_L, S_FIN
	} state_t;

	typedef enum logic [3:0] {
		CMD_NONE, CMD_START, CMD_SCAN_RD, CMD_SCAN_EV, CMD_EV_START, CMD_DIV,
		CMD_VF_RD, CMD_VF_EV, CMD_RN_RD, CMD_MERGE, CMD_MSH_RD, CMD_MSH_WR,
		CMD_MEND, CMD_PLACE, CMD_PSH_RD, CMD_PSH_WR
	} cmd_base_t;

	typedef struct packed {
		cmd_base_t op;
		logic      fix_r;
		logic      fix_l;
		logic      fin;
	} cmd_t;

	typedef struct packed {
		logic scan_stop;
		logic fit_ok;
		logic none_left;
		logic div_last;
		logic vf_hit;
		logic vf_last;
		logic shift_more;
		logic merged_ok;
		logic split;
		logic psh_more;
		logic out_free;
	} stat_t;

endpackage

// ===== design/vpa_ifs.sv =====
// Valid/ready channel interfaces: request, result and configuration write.
// Depends on vpa_pkg for field widths.
interface vpa_req_if;
	import vpa_pkg::*;
	logic          valid;
	logic          ready;
	logic [RW-1:0] request_size;
	modport source (output valid, request_size, input ready);
	modport sink (input valid, request_size, output ready);
endinterface

interface vpa_res_if;
	import vpa_pkg::*;
	logic          valid;
	logic          ready;
	logic [AW-1:0] placed_index;
	logic [EW-1:0] eviction_count;
	logic [HW-1:0] holes_examined;
	modport source (output valid, placed_index, eviction_count, holes_examined, input ready);
	modport sink (input valid, placed_index, eviction_count, holes_examined, output ready);
endinterface

interface vpa_cfg_if;
	import vpa_pkg::*;
	logic          valid;
	logic          ready;
	logic [IW-1:0] index;
	logic [LW-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== design/vpa_ctrl.sv =====
// Sequencer for the allocator: scan, eviction, merge shift, split shift, result.
// Depends on vpa_pkg; drives commands into vpa_dp and reads its status.
module vpa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  vpa_pkg::stat_t st,
	output vpa_pkg::cmd_t  cmd
);
	import vpa_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		cmd       = '{op: CMD_NONE, fix_r: 1'b0, fix_l: 1'b0, fin: 1'b0};
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.op  = CMD_START;
					state_d = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				cmd.op  = CMD_SCAN_RD;
				state_d = S_SCAN_EV;
			end
			S_SCAN_EV: begin
				cmd.op  = CMD_SCAN_EV;
				state_d = st.scan_stop ? S_DECIDE : S_SCAN_RD;
			end
			S_DECIDE: begin
				if (st.fit_ok) state_d = S_PLACE;
				else if (st.none_left) state_d = S_FIN;
				else state_d = S_EVST;
			end
			S_EVST: begin
				cmd.op  = CMD_EV_START;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.op = CMD_DIV;
				if (st.div_last) state_d = S_VF_RD;
			end
			S_VF_RD: begin
				cmd.op  = CMD_VF_RD;
				state_d = S_VF_EV;
			end
			S_VF_EV: begin
				cmd.op = CMD_VF_EV;
				if (st.vf_hit) state_d = S_RN_RD;
				else if (st.vf_last) state_d = S_FIN;
				else state_d = S_VF_RD;
			end
			S_RN_RD: begin
				cmd.op  = CMD_RN_RD;
				state_d = S_MERGE;
			end
			S_MERGE: begin
				cmd.op  = CMD_MERGE;
				state_d = S_MLOOP;
			end
			S_MLOOP: state_d = st.shift_more ? S_MSH_RD : S_MEND;
			S_MSH_RD: begin
				cmd.op  = CMD_MSH_RD;
				state_d = S_MSH_WR;
			end
			S_MSH_WR: begin
				cmd.op  = CMD_MSH_WR;
				state_d = S_MLOOP;
			end
			S_MEND: begin
				cmd.op = CMD_MEND;
				if (st.merged_ok) state_d = S_PLACE;
				else if (st.none_left) state_d = S_FIN;
				else state_d = S_EVST;
			end
			S_PLACE: begin
				cmd.op  = CMD_PLACE;
				state_d = st.split ? S_PLOOP : S_FIN;
			end
			S_PLOOP: state_d = st.psh_more ? S_PSH_RD : S_PFIX_R;
			S_PSH_RD: begin
				cmd.op  = CMD_PSH_RD;
				state_d = S_PSH_WR;
			end
			S_PSH_WR: begin
				cmd.op  = CMD_PSH_WR;
				state_d = S_PLOOP;
			end
			S_PFIX_R: begin
				cmd.fix_r = 1'b1;
				state_d   = S_PFIX_L;
			end
			S_PFIX_L: begin
				cmd.fix_l = 1'b1;
				state_d   = S_FIN;
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				if (st.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== design/vpa_dp.sv =====
// Allocator datapath: segment table memory, counters, divider, LFSR, result register.
// Depends on vpa_pkg and the channel interfaces; driven by vpa_ctrl commands.
module vpa_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  vpa_pkg::cmd_t  cmd,
	output vpa_pkg::stat_t st,
	input  logic [vpa_pkg::RW-1:0] request_size,
	vpa_res_if.source      res,
	vpa_cfg_if.sink        cfg
);
	import vpa_pkg::*;

	ent_t          mem [MAX_SEGS];
	ent_t          rd_q;
	logic          rd0_q, v0_q;
	ent_t          rd_ent;
	logic          wr_en;
	logic [AW-1:0] wr_addr, rd_addr;
	ent_t          wr_data;

	logic [1:0]    policy_q;
	logic [LW-1:0] lfsr_q, lfsr_nx, dvd_q;
	logic [CW-1:0] total_q, pcount_q, idx_q, j_q, seen_q, rem_q;
	logic [3:0]    dcnt_q;
	logic [SW-1:0] need_q, best_q, lsize_q, vsize_q, psize_q;
	logic [AW-1:0] loc_q, v_q;
	logic          found_q, phole_q;
	logic [1:0]    d_q;
	logic [EW-1:0] evict_q;
	logic [HW-1:0] checks_q;
	logic          out_valid_q;
	logic [AW-1:0] out_loc_q;
	logic [EW-1:0] out_ev_q;
	logic [HW-1:0] out_ck_q;

	// scan evaluation
	logic          ge_need, first_hit;
	// merge
	logic          left, right, full;
	logic [SW:0]   msum;
	logic [AW-1:0] mloc;
	logic [1:0]    mdrop;
	// divider step
	logic [CW:0]   rsh;
	logic          rge;

	assign rd_ent    = rd0_q ? '{size: SW'(MEM_UNITS), hole: 1'b1} : rd_q;
	assign ge_need   = rd_ent.size >= need_q;
	assign first_hit = rd_ent.hole && ge_need && policy_q[1];

	assign left  = (v_q != '0) && phole_q;
	assign right = ({1'b0, v_q} + 1'b1 < total_q) && rd_ent.hole;
	assign full  = vsize_q == SW'(MEM_UNITS);
	assign msum  = {1'b0, vsize_q} + (left ? {1'b0, psize_q} : '0)
	             + (right ? {1'b0, rd_ent.size} : '0);
	assign mloc  = (!full && left) ? v_q - 1'b1 : v_q;
	assign mdrop = full ? 2'd0 : {1'b0, left} + {1'b0, right};

	assign rsh = {rem_q, dvd_q[LW-1]};
	assign rge = rsh >= {1'b0, pcount_q};

	assign lfsr_nx = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[LW-1:1]};

	always_comb begin
		st.scan_stop  = first_hit || (idx_q + 1'b1 == total_q);
		st.fit_ok     = (policy_q == POL_WORST) ? (best_q >= need_q) : found_q;
		st.none_left  = pcount_q == '0;
		st.div_last   = dcnt_q == 4'd15;
		st.vf_hit     = !rd_ent.hole && (seen_q == rem_q);
		st.vf_last    = idx_q + 1'b1 == total_q;
		st.shift_more = j_q + CW'(d_q) < total_q;
		st.merged_ok  = lsize_q >= need_q;
		st.split      = !(lsize_q == need_q || total_q == CW'(MAX_SEGS));
		st.psh_more   = j_q > {1'b0, loc_q} + 1'b1;
		st.out_free   = !out_valid_q || res.ready;
	end

	always_comb begin
		rd_addr = idx_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = j_q[AW-1:0];
		wr_data = rd_ent;
		case (cmd.op)
			CMD_RN_RD:  rd_addr = v_q + 1'b1;
			CMD_MSH_RD: rd_addr = AW'(j_q + CW'(d_q));
			CMD_PSH_RD: rd_addr = AW'(j_q - 1'b1);
			CMD_MERGE: begin
				wr_en   = 1'b1;
				wr_addr = mloc;
				wr_data = '{size: full ? vsize_q : msum[SW-1:0], hole: 1'b1};
			end
			CMD_MSH_WR, CMD_PSH_WR: wr_en = 1'b1;
			CMD_PLACE: begin
				wr_en   = !st.split;
				wr_addr = loc_q;
				wr_data = '{size: lsize_q, hole: 1'b0};
			end
			default: ;
		endcase
		if (cmd.fix_r) begin
			wr_en   = 1'b1;
			wr_addr = loc_q + 1'b1;
			wr_data = '{size: lsize_q - need_q, hole: 1'b1};
		end
		if (cmd.fix_l) begin
			wr_en   = 1'b1;
			wr_addr = loc_q;
			wr_data = '{size: need_q, hole: 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	// entry zero reads as the reset hole until its first write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q  <= 1'b0;
			rd0_q <= 1'b0;
		end else begin
			if (wr_en && wr_addr == '0) v0_q <= 1'b1;
			rd0_q <= (rd_addr == '0) && !v0_q && !(wr_en && wr_addr == '0);
		end
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q    <= POL_BEST;
			lfsr_q      <= LW'(1);
			total_q     <= CW'(1);
			pcount_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				if (cfg.index == REG_FIT_POLICY) policy_q <= cfg.data[1:0];
				if (cfg.index == REG_VICTIM_SEED)
					lfsr_q <= (cfg.data == '0) ? LW'(1) : cfg.data;
			end
			case (cmd.op)
				CMD_EV_START: lfsr_q <= lfsr_nx;
				CMD_MERGE:    pcount_q <= pcount_q - 1'b1;
				CMD_MEND:     total_q <= total_q - CW'(d_q);
				CMD_PLACE:    if (!st.split) pcount_q <= pcount_q + 1'b1;
				default: ;
			endcase
			if (cmd.fix_l) begin
				total_q  <= total_q + 1'b1;
				pcount_q <= pcount_q + 1'b1;
			end
			if (cmd.fin && st.out_free) out_valid_q <= 1'b1;
			else if (res.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			CMD_START: begin
				if (request_size == '0) need_q <= SW'(1);
				else if (request_size > RW'(MEM_UNITS)) need_q <= SW'(MEM_UNITS);
				else need_q <= SW'(request_size);
				idx_q    <= '0;
				found_q  <= 1'b0;
				best_q   <= '0;
				loc_q    <= '0;
				lsize_q  <= '0;
				checks_q <= '0;
				evict_q  <= '0;
			end
			CMD_SCAN_EV: begin
				idx_q <= idx_q + 1'b1;
				if (rd_ent.hole) begin
					checks_q <= checks_q + 1'b1;
					if (policy_q == POL_BEST) begin
						if (ge_need && (!found_q || rd_ent.size < best_q)) begin
							found_q <= 1'b1;
							best_q  <= rd_ent.size;
							loc_q   <= idx_q[AW-1:0];
							lsize_q <= rd_ent.size;
						end
					end else if (policy_q == POL_WORST) begin
						if (rd_ent.size > best_q) begin
							best_q  <= rd_ent.size;
							loc_q   <= idx_q[AW-1:0];
							lsize_q <= rd_ent.size;
						end
					end else if (ge_need) begin
						found_q <= 1'b1;
						loc_q   <= idx_q[AW-1:0];
						lsize_q <= rd_ent.size;
					end
				end
			end
			CMD_EV_START: begin
				dvd_q   <= lfsr_nx;
				rem_q   <= '0;
				dcnt_q  <= '0;
				idx_q   <= '0;
				seen_q  <= '0;
				phole_q <= 1'b0;
			end
			CMD_DIV: begin
				rem_q  <= rge ? CW'(rsh - {1'b0, pcount_q}) : CW'(rsh);
				dvd_q  <= {dvd_q[LW-2:0], 1'b0};
				dcnt_q <= dcnt_q + 1'b1;
			end
			CMD_VF_EV: begin
				if (st.vf_hit) begin
					v_q     <= idx_q[AW-1:0];
					vsize_q <= rd_ent.size;
				end else begin
					if (!rd_ent.hole) seen_q <= seen_q + 1'b1;
					phole_q <= rd_ent.hole;
					psize_q <= rd_ent.size;
					idx_q   <= idx_q + 1'b1;
				end
			end
			CMD_MERGE: begin
				loc_q   <= mloc;
				lsize_q <= full ? vsize_q : msum[SW-1:0];
				d_q     <= mdrop;
				j_q     <= {1'b0, mloc} + 1'b1;
				if (evict_q != '1) evict_q <= evict_q + 1'b1;
			end
			CMD_MSH_WR: j_q <= j_q + 1'b1;
			CMD_PLACE:  j_q <= total_q;
			CMD_PSH_WR: j_q <= j_q - 1'b1;
			default: ;
		endcase
		if (cmd.fin && st.out_free) begin
			out_loc_q <= loc_q;
			out_ev_q  <= evict_q;
			out_ck_q  <= checks_q;
		end
	end

	assign res.valid          = out_valid_q;
	assign res.placed_index   = out_loc_q;
	assign res.eviction_count = out_ev_q;
	assign res.holes_examined = out_ck_q;

endmodule

// ===== design/variable_partition_allocator.sv =====
// Variable partition allocator: a request of 1..1024 units takes one word and
// yields one result word. A request scans the segment table entry by entry,
// a read then an evaluation (one memory read port), stopping early for first
// fit at the first hole that fits. Each eviction adds one LFSR step, a
// remainder step, a victim search (read, evaluate per entry) and a shift
// (loop check, read, write per entry) to close merged entries. A split adds
// a shift of the same kind to open a slot, then writes the new pair. The time
// per request therefore grows with table length and with evictions; a request
// that evicts many partitions from a long table can take far more than a plain
// scan. One request is in work at a time; the next is taken once the previous
// result is in the output register.
// Depends on vpa_pkg, the channel interfaces, vpa_ctrl and vpa_dp.
module variable_partition_allocator (
	input  logic       clk,
	input  logic       arst_n,
	vpa_req_if.sink    req,
	vpa_res_if.source  res,
	vpa_cfg_if.sink    cfg
);
	import vpa_pkg::*;

	cmd_t  cmd;
	stat_t st;

	vpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.st        (st),
		.cmd       (cmd)
	);

	vpa_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.request_size (req.request_size),
		.res          (res),
		.cfg          (cfg)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while another is in work");

	a_fin_loads: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin && st.out_free |=> res.valid && req.ready)
		else $error("finished word not presented");

	// write is followed by the loop check cycle, then a read or the end
	a_shift_loop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == CMD_MSH_WR |=> ##1 (cmd.op == CMD_MSH_RD || cmd.op == CMD_MEND))
		else $error("merge shift loop broken");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == CMD_EV_START |=> cmd.op == CMD_DIV)
		else $error("remainder step missing");

endmodule
